[design/vmex_pkg.sv]
// Package: shared types and opcode constants for the VM execute unit.
`timescale 1ns / 1ps
`default_nettype none
package vmex_pkg;
    typedef struct packed {
        logic [5:0]  command;
        logic [63:0] first_operand;
        logic [63:0] second_operand;
        logic [63:0] third_operand;
    } in_item_t;

    typedef struct packed {
        logic        pc_written;
        logic        exit_request;
        logic [1:0]  error_code;
        logic [63:0] program_counter;
    } out_item_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_ADDR = 2'd1,
        ERR_DIV0 = 2'd2,
        ERR_SCALL = 2'd3
    } err_code_t;

    localparam logic [5:0] OP_SCALL = 6'd0;
    localparam logic [5:0] OP_LOAD = 6'd1;
    localparam logic [5:0] OP_LOADI = 6'd2;
    localparam logic [5:0] OP_LOADA = 6'd3;
    localparam logic [5:0] OP_SAVEAI = 6'd7;
    localparam logic [5:0] OP_ALU_LAST = 6'd21;
    localparam logic [5:0] OP_NOT = 6'd22;
    localparam logic [5:0] OP_NOTI = 6'd23;
    localparam logic [5:0] OP_CMP_LAST = 6'd35;
    localparam logic [5:0] OP_JRE_LAST = 6'd37;
    localparam logic [5:0] OP_JEQ_LAST = 6'd39;
    localparam logic [5:0] OP_JNE_LAST = 6'd41;
    localparam logic [5:0] OP_JMP_LAST = 6'd43;

    localparam logic [1:0] CFG_MEM_CHECK = 2'd0;
    localparam logic [1:0] CFG_MATH_CHECK = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE = 2'd2;

    // Instruction class decided in the front end
    typedef enum logic [3:0] {
        CL_NOP, CL_SCALL, CL_MOV, CL_MOVI, CL_LOADA, CL_STORE, CL_ALU,
        CL_NOT, CL_NOTI, CL_CMP, CL_JREL, CL_JEQ, CL_JNE, CL_JMP
    } op_class_t;

    typedef struct packed {
        op_class_t   cls;
        logic [2:0]  sub;
        logic        imm;
        logic        addr_reg;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } dec_item_t;
endpackage
`default_nettype wire

[design/vmex_front.sv]
// Front end: accepts instructions, classifies them, two-entry queue to the back end.
`timescale 1ns / 1ps
`default_nettype none
module vmex_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  vmex_pkg::in_item_t        in_item,
    output logic                      q_valid,
    input  wire logic                 q_take,
    output vmex_pkg::dec_item_t       q_item
);
    import vmex_pkg::*;

    dec_item_t slot_reg [2];
    logic      rd_ptr_reg, wr_ptr_reg;
    logic [1:0] count_reg;
    dec_item_t dec;
    logic      push, pop;

    // Classify the command
    always_comb
    begin
        logic [5:0] cmd;
        logic [5:0] rel;
        cmd = in_item.command;
        dec.a = in_item.first_operand;
        dec.b = in_item.second_operand;
        dec.c = in_item.third_operand;
        dec.imm = cmd[0];
        dec.sub = 3'd0;
        dec.addr_reg = 1'b0;
        dec.cls = CL_NOP;
        rel = 6'd0;
        if (cmd == OP_SCALL) dec.cls = CL_SCALL;
        else if (cmd == OP_LOAD) dec.cls = CL_MOV;
        else if (cmd == OP_LOADI) dec.cls = CL_MOVI;
        else if (cmd == OP_LOADA) dec.cls = CL_LOADA;
        else if (cmd <= OP_SAVEAI)
        begin
            dec.cls = CL_STORE;
            dec.addr_reg = (cmd <= 6'd5);
        end
        else if (cmd <= OP_ALU_LAST)
        begin
            dec.cls = CL_ALU;
            rel = cmd - 6'd8;
            dec.sub = rel[3:1];
        end
        else if (cmd == OP_NOT) dec.cls = CL_NOT;
        else if (cmd == OP_NOTI) dec.cls = CL_NOTI;
        else if (cmd <= OP_CMP_LAST)
        begin
            dec.cls = CL_CMP;
            rel = cmd - 6'd24;
            dec.sub = rel[3:1];
        end
        else if (cmd <= OP_JRE_LAST) dec.cls = CL_JREL;
        else if (cmd <= OP_JEQ_LAST) dec.cls = CL_JEQ;
        else if (cmd <= OP_JNE_LAST) dec.cls = CL_JNE;
        else if (cmd <= OP_JMP_LAST) dec.cls = CL_JMP;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign pop = q_take && q_valid;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= dec;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && !pop |=> count_reg == 2'd2)
        else $error("queue count changed without pop");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

[design/vmex_back.sv]
// Back end: executes classified instructions on the register file and memory.
`timescale 1ns / 1ps
`default_nettype none
module vmex_back
#(
    parameter int REG_COUNT = 16,
    parameter int MEM_DEPTH = 65536,
    parameter int PC_INDEX = 0,
    parameter int EQ_INDEX = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_take,
    input  vmex_pkg::dec_item_t       q_item,
    input  wire logic                 mem_check,
    input  wire logic                 math_check,
    input  wire logic [16:0]          mem_limit,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output vmex_pkg::out_item_t       out_item
);
    import vmex_pkg::*;

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [RW-1:0] PC_I = RW'(PC_INDEX);
    localparam logic [RW-1:0] EQ_I = RW'(EQ_INDEX);
    localparam logic PC_OK = (PC_INDEX < REG_COUNT);
    localparam logic EQ_OK = (EQ_INDEX < REG_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_MEM, S_DONE
    } state_t;

    state_t      state_reg;
    dec_item_t   op_reg;
    logic [63:0] regs_reg [REG_COUNT];
    logic [7:0]  mem_reg [MEM_DEPTH];
    logic [7:0]  mem_rd_reg;
    logic [63:0] x_reg, y_reg, ra_reg;
    logic [63:0] quo_reg, rem_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] mlo_reg, mhi_reg, mmid_reg;
    logic        ld_ok_reg;
    logic        pcw_reg, ex_reg;
    logic [1:0]  err_reg;
    logic        out_valid_reg;
    logic [63:0] pc_out_reg;

    // Register file reads by operand index
    logic [63:0] rb_val, rc_val, raa_val, pc_val, eq_val;
    assign rb_val = (op_reg.b < 64'(REG_COUNT)) ? regs_reg[op_reg.b[RW-1:0]] : 64'd0;
    assign rc_val = (op_reg.c < 64'(REG_COUNT)) ? regs_reg[op_reg.c[RW-1:0]] : 64'd0;
    assign raa_val = (op_reg.a < 64'(REG_COUNT)) ? regs_reg[op_reg.a[RW-1:0]] : 64'd0;
    assign pc_val = PC_OK ? regs_reg[PC_I] : 64'd0;
    assign eq_val = EQ_OK ? regs_reg[EQ_I] : 64'd0;

    function automatic logic in_range(input logic [63:0] ad, input logic [16:0] rs);
        return (ad < {47'd0, rs}) && (ad < 64'(MEM_DEPTH));
    endfunction

    // Take a new item only in idle, once the previous result has been taken or is taken in this cycle
    assign q_take = (state_reg == S_IDLE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item.pc_written = pcw_reg;
    assign out_item.exit_request = ex_reg;
    assign out_item.error_code = err_reg;
    assign out_item.program_counter = pc_out_reg;

    // Restoring divide step
    logic [64:0] dv_trial;
    logic [63:0] dv_rem_sh;
    assign dv_rem_sh = {rem_reg[62:0], quo_reg[63]};
    assign dv_trial = {rem_reg[63], dv_rem_sh} - {1'b0, y_reg};

    logic [63:0] wr_val;
    logic        wr_en;
    logic [63:0] wr_idx;
    logic        do_store;
    logic [63:0] st_addr;
    logic [1:0]  e_err;
    logic        e_pcw, e_ex;

    // Execute stage result
    always_comb
    begin
        logic [63:0] t, tgt;
        logic jmp, r;
        wr_val = 64'd0;
        wr_en = 1'b0;
        wr_idx = op_reg.a;
        do_store = 1'b0;
        st_addr = op_reg.addr_reg ? ra_reg : op_reg.a;
        e_err = ERR_NONE;
        e_pcw = 1'b0;
        e_ex = 1'b0;
        jmp = 1'b0;
        r = 1'b0;
        t = op_reg.imm ? op_reg.a : ra_reg;
        tgt = t;
        case (op_reg.cls)
            CL_SCALL:
            begin
                if (op_reg.a == 64'd1) e_ex = 1'b1;
                else if (op_reg.a != 64'd0) e_err = ERR_SCALL;
            end
            CL_MOV: begin wr_en = 1'b1; wr_val = x_reg; end
            CL_MOVI: begin wr_en = 1'b1; wr_val = op_reg.b; end
            CL_LOADA:
            begin
                if (math_check && !ld_ok_reg) e_err = ERR_ADDR;
                else
                begin
                    wr_en = 1'b1;
                    wr_val = (op_reg.b < 64'(MEM_DEPTH)) ? {56'd0, mem_rd_reg} : 64'd0;
                end
            end
            CL_STORE:
            begin
                if (mem_check && !in_range(st_addr, mem_limit)) e_err = ERR_ADDR;
                else do_store = (st_addr < 64'(MEM_DEPTH));
            end
            CL_ALU:
            begin
                wr_en = 1'b1;
                case (op_reg.sub)
                    3'd0: wr_val = x_reg + y_reg;
                    3'd1: wr_val = x_reg - y_reg;
                    3'd2: wr_val = mlo_reg;
                    3'd3:
                    begin
                        if (y_reg == 64'd0)
                        begin
                            if (math_check) begin e_err = ERR_DIV0; wr_en = 1'b0; end
                            else wr_val = '1;
                        end
                        else wr_val = quo_reg;
                    end
                    3'd4: wr_val = x_reg & y_reg;
                    3'd5: wr_val = x_reg | y_reg;
                    default: wr_val = x_reg ^ y_reg;
                endcase
            end
            CL_NOT: begin wr_en = 1'b1; wr_val = ~x_reg; end
            CL_NOTI: begin wr_en = 1'b1; wr_val = ~op_reg.b; end
            CL_CMP:
            begin
                case (op_reg.sub)
                    3'd0: r = (ra_reg == y_reg);
                    3'd1: r = (ra_reg != y_reg);
                    3'd2: r = (ra_reg > y_reg);
                    3'd3: r = (ra_reg >= y_reg);
                    3'd4: r = (ra_reg < y_reg);
                    default: r = (ra_reg <= y_reg);
                endcase
                wr_en = 1'b1;
                wr_idx = 64'(EQ_INDEX);
                wr_val = {63'd0, r};
            end
            CL_JREL: begin jmp = 1'b1; tgt = pc_val + t; end
            CL_JEQ: jmp = (eq_val != 64'd0);
            CL_JNE: jmp = (eq_val == 64'd0);
            CL_JMP: jmp = 1'b1;
            default: ;
        endcase
        if (jmp)
        begin
            if (mem_check && !in_range(tgt, mem_limit)) e_err = ERR_ADDR;
            else
            begin
                wr_en = 1'b1;
                wr_idx = 64'(PC_INDEX);
                wr_val = tgt;
                e_pcw = 1'b1;
            end
        end
        if (wr_idx >= 64'(REG_COUNT)) wr_en = 1'b0;
    end

    // Memory port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && do_store)
            mem_reg[st_addr[AW-1:0]] <= x_reg[7:0];
        mem_rd_reg <= mem_reg[op_reg.b[AW-1:0]];
    end

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++) regs_reg[i] <= 64'd0;
        end
        else if (state_reg == S_EXEC && wr_en)
        begin
            regs_reg[wr_idx[RW-1:0]] <= wr_val;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_take)
                    begin
                        op_reg <= q_item;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    x_reg <= (op_reg.cls == CL_STORE && op_reg.imm) ? op_reg.b : rb_val;
                    ra_reg <= raa_val;
                    y_reg <= (op_reg.cls == CL_CMP) ? (op_reg.imm ? op_reg.b : rb_val)
                           : (op_reg.cls == CL_STORE) ? 64'd0
                           : (op_reg.imm ? op_reg.c : rc_val);
                    ld_ok_reg <= in_range(op_reg.b, mem_limit);
                    cnt_reg <= 7'd0;
                    quo_reg <= rb_val;
                    rem_reg <= 64'd0;
                    if (op_reg.cls == CL_ALU && op_reg.sub == 3'd2) state_reg <= S_MUL;
                    else if (op_reg.cls == CL_ALU && op_reg.sub == 3'd3) state_reg <= S_DIV;
                    else if (op_reg.cls == CL_LOADA) state_reg <= S_MEM;
                    else state_reg <= S_EXEC;
                end
                S_MEM: state_reg <= S_EXEC;
                S_MUL:
                begin
                    // Three 32x32 partial products, then the step that combines them
                    cnt_reg <= cnt_reg + 7'd1;
                    case (cnt_reg[1:0])
                        2'd0: mlo_reg <= x_reg[31:0] * y_reg[31:0];
                        2'd1: mmid_reg <= 64'(x_reg[63:32] * y_reg[31:0]);
                        2'd2: mhi_reg <= 64'(x_reg[31:0] * y_reg[63:32]);
                        default:
                        begin
                            mlo_reg <= mlo_reg + {mmid_reg[31:0] + mhi_reg[31:0], 32'd0};
                            state_reg <= S_EXEC;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (y_reg == 64'd0) state_reg <= S_EXEC;
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                        if (!dv_trial[64]) rem_reg <= dv_trial[63:0];
                        else rem_reg <= dv_rem_sh;
                        quo_reg <= {quo_reg[62:0], !dv_trial[64]};
                        if (cnt_reg == 7'd63) state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    pcw_reg <= e_pcw;
                    ex_reg <= e_ex;
                    err_reg <= e_err;
                    pc_out_reg <= (e_pcw && PC_OK) ? wr_val
                                : (wr_en && wr_idx == 64'(PC_INDEX)) ? wr_val : pc_val;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Result register is free here: it was taken no later than when this item was taken
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == S_IDLE) else $error("take outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_DONE) else $error("exec not followed by done");
endmodule
`default_nettype wire

[design/vm_instruction_execute_unit_top.sv]
// Top level: configuration registers, front end queue and execute back end.
`timescale 1ns / 1ps
`default_nettype none
// Executes one decoded VM instruction per item against a register file and a
// byte memory and returns one result item per instruction. Each instruction
// passes through a read state, an execute state and a done state before its
// result is offered; a byte load adds a memory read state, multiply adds its
// multiply state for the 32-bit partial products and divide adds its bit-serial
// restoring divider (left at once when the divisor is zero). The back end takes
// a new item only in idle, after the last one is done, and only once its result
// has been taken or is taken in the same cycle. The front end queues up to two
// items so the input side keeps moving while the back end works. The user must
// write configuration only while idle; the block does not enforce it.
module vm_instruction_execute_unit_top
#(
    parameter int REG_COUNT = 16,
    parameter int MEM_DEPTH = 65536,
    parameter int PC_INDEX = 0,
    parameter int EQ_INDEX = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  vmex_pkg::in_item_t        in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output vmex_pkg::out_item_t       out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [16:0]          cfg_data
);
    import vmex_pkg::*;

    logic        mem_check_reg, math_check_reg;
    logic [16:0] mem_limit_reg;
    logic        q_valid, q_take;
    dec_item_t   q_item;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_check_reg <= 1'b1;
            math_check_reg <= 1'b1;
            mem_limit_reg <= 17'd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MEM_CHECK: mem_check_reg <= cfg_data[0];
                CFG_MATH_CHECK: math_check_reg <= cfg_data[0];
                CFG_RAM_SIZE: mem_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vmex_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    vmex_back #(.REG_COUNT(REG_COUNT), .MEM_DEPTH(MEM_DEPTH),
                .PC_INDEX(PC_INDEX), .EQ_INDEX(EQ_INDEX)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .mem_check(mem_check_reg), .math_check(math_check_reg), .mem_limit(mem_limit_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );
endmodule
`default_nettype wire
